// ===== design/spe_pkg.sv =====
package spe_pkg;

  localparam int MODEL_DIM_DEF     = 560;
  localparam int MAX_POSITIONS_DEF = 4096;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int ROW_W   = 12;
  localparam int CH_W    = 9;
  localparam int RES_W   = 16;
  localparam int INV_W   = 25;
  localparam int POS_W   = ROW_W + 1;
  localparam int ANGLE_W = POS_W + INV_W;
  localparam int PHASE_W = 32;
  localparam int XY_W    = 34;
  localparam int Z_W     = PHASE_W + 1;
  localparam int MAX_CELLS = 24;

  localparam logic [29:0] INV_2PI_Q32     = 30'd683565276;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [CH_W-1:0]  channel_index;
  } spe_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] sin_value;
    logic signed [RES_W-1:0] cos_value;
  } spe_result_t;

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic [1:0]             quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } spe_cell_t;

endpackage

// ===== design/sinusoidal_position_encoder.sv =====
// Sinusoidal position encoder: for a row index t and a channel index i it
// returns sin and cos of (t+1) * 10000^(-i/(MODEL_DIM/2-1)) in Q1.15, the
// sine for channel i and the cosine for channel i plus half the dimension.
// busy stays low, so a new word may be started in every clock cycle; each
// result appears with done high for one cycle, in start order. Each word
// passes a registered timescale lookup, the position multiply, the
// conversion to turns, the octant fold, the chain of CORDIC cells (one
// rotation per cell) and the output register. The receiver cannot stall
// the block: a result not taken in its cycle is gone. A channel index
// at or above half the model dimension, or a row index at or above
// MAX_POSITIONS, returns zero for both.
module sinusoidal_position_encoder
  import spe_pkg::*;
#(
  parameter int MODEL_DIM     = MODEL_DIM_DEF,
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  spe_item_t   item,
  output logic        done,
  output spe_result_t result
);

  localparam int HALF      = MODEL_DIM / 2;
  localparam int DEPTH     = (HALF < (1 << CH_W)) ? HALF : (1 << CH_W);
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NUM_CELLS = (CORDIC_STAGES > MAX_CELLS) ? MAX_CELLS : CORDIC_STAGES;
  localparam int LATENCY   = NUM_CELLS + 6;

  localparam int FRAC_W   = 24;
  localparam int HI_W     = ANGLE_W - FRAC_W;
  localparam int K_W      = 30;
  localparam int HI_PW    = HI_W + K_W;
  localparam int LO_PW    = FRAC_W + K_W;
  localparam int Q_W      = XY_W - 14;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [PHASE_W-1:0] EIGHTH_TURN = 32'h2000_0000;
  localparam logic [XY_W:0]      ROUND_HALF  = (XY_W + 1)'(1 << 14);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

  function automatic logic signed [RES_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic [XY_W:0]          t;
    logic signed [Q_W-1:0]  q;
    logic signed [RES_W-1:0] r;
    t = {v[XY_W-1], v} + ROUND_HALF;
    q = t[XY_W:15];
    if (q > Q_MAX) begin
      r = 16'sd32767;
    end else if (q < Q_MIN) begin
      r = -16'sd32768;
    end else begin
      r = RES_W'(q);
    end
    return r;
  endfunction

  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] rom_addr;

  logic               a_valid;
  logic               a_zero;
  logic [POS_W-1:0]   a_pos;
  logic [INV_W-1:0]   a_inv;
  logic               b_valid;
  logic               b_zero;
  logic [ANGLE_W-1:0] b_angle;
  logic               c_valid;
  logic               c_zero;
  logic [PHASE_W-1:0] c_hi;
  logic [K_W-1:0]     c_lo;
  logic               d_valid;
  logic               d_zero;
  logic [PHASE_W-1:0] d_phase;

  logic [PHASE_W-1:0] quad_sum;
  logic [1:0]         fold_quad;
  logic [PHASE_W-1:0] fold_z;
  logic [HI_PW-1:0]   hi_prod;
  logic [LO_PW-1:0]   lo_prod;

  spe_cell_t head;
  spe_cell_t chain [NUM_CELLS];
  spe_cell_t last;

  logic signed [XY_W-1:0] lx;
  logic signed [XY_W-1:0] ly;
  logic signed [XY_W-1:0] cv;
  logic signed [XY_W-1:0] sv;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign in_range = (32'(item.channel_index) < HALF) && (32'(item.row_index) < MAX_POSITIONS);
  assign rom_addr = in_range ? item.channel_index[ADDR_W-1:0] : '0;

  spe_timescale_rom #(
    .HALF (HALF)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (a_inv)
  );

  always_ff @(posedge clk) begin
    a_pos <= POS_W'(item.row_index) + POS_W'(1);
    a_zero <= !in_range;
    b_angle <= ANGLE_W'(a_pos) * ANGLE_W'(a_inv);
    b_zero <= a_zero;
    c_hi <= hi_prod[PHASE_W-1:0];
    c_lo <= lo_prod[LO_PW-1:FRAC_W];
    c_zero <= b_zero;
    d_phase <= c_hi + PHASE_W'(c_lo);
    d_zero <= c_zero;
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  assign hi_prod = HI_PW'(b_angle[ANGLE_W-1:FRAC_W]) * HI_PW'(INV_2PI_Q32);
  assign lo_prod = LO_PW'(b_angle[FRAC_W-1:0]) * LO_PW'(INV_2PI_Q32);

  assign quad_sum  = d_phase + EIGHTH_TURN;
  assign fold_quad = quad_sum[PHASE_W-1:PHASE_W-2];
  assign fold_z    = d_phase - {fold_quad, 30'd0};

  always_ff @(posedge clk) begin
    head.zero <= d_zero;
    head.quad <= fold_quad;
    head.x    <= XY_W'(CORDIC_GAIN_Q30);
    head.y    <= '0;
    head.z    <= {fold_z[PHASE_W-1], fold_z};
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= d_valid;
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : gen_cell
    if (g == 0) begin : gen_first
      spe_cordic_cell #(
        .SHIFT (g)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_in  (head),
        .cell_out (chain[g])
      );
    end else begin : gen_next
      spe_cordic_cell #(
        .SHIFT (g)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_in  (chain[g-1]),
        .cell_out (chain[g])
      );
    end
  end

  assign last = chain[NUM_CELLS-1];

  always_comb begin
    lx = last.x;
    ly = last.y;
    case (last.quad)
      QUAD_0: begin
        cv = lx;
        sv = ly;
      end
      QUAD_1: begin
        cv = -ly;
        sv = lx;
      end
      QUAD_2: begin
        cv = -lx;
        sv = -ly;
      end
      QUAD_3: begin
        cv = ly;
        sv = -lx;
      end
      default: begin
        cv = lx;
        sv = ly;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (last.zero) begin
      result <= '0;
    end else begin
      result.sin_value <= to_q15(sv);
      result.cos_value <= to_q15(cv);
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
  end

  // Every started word comes out after the fixed latency.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("started word did not complete on time");

  // No result appears without a matching start.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a started word");

  // A channel outside the table gives zero for both values.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (32'(item.channel_index) >= HALF)) |-> ##LATENCY (result == '0))
    else $error("out-of-range channel did not give zero");

endmodule

// ===== design/spe_timescale_rom.sv =====
module spe_timescale_rom
  import spe_pkg::*;
#(
  parameter int HALF = MODEL_DIM_DEF / 2,
  localparam int DEPTH = (HALF < (1 << CH_W)) ? HALF : (1 << CH_W),
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [INV_W-1:0]  data
);

  localparam logic [63:0] LOG2_1E4_Q32 = 64'd57070290109;
  localparam logic [63:0] LN2_Q32      = 64'd2977044472;
  localparam int          EXP_TERMS    = 16;
  localparam logic [63:0] TS_DIV       = (HALF > 1) ? 64'(HALF - 1) : 64'd1;

  function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
    logic [63:0] q;
    case (k)
      2:       q = v / 64'd2;
      3:       q = v / 64'd3;
      4:       q = v / 64'd4;
      5:       q = v / 64'd5;
      6:       q = v / 64'd6;
      7:       q = v / 64'd7;
      8:       q = v / 64'd8;
      9:       q = v / 64'd9;
      10:      q = v / 64'd10;
      11:      q = v / 64'd11;
      12:      q = v / 64'd12;
      13:      q = v / 64'd13;
      14:      q = v / 64'd14;
      15:      q = v / 64'd15;
      16:      q = v / 64'd16;
      default: q = v;
    endcase
    return q;
  endfunction

  // The exponent is split into a whole power of two and a fraction whose
  // power is taken from a series for exp(-f*ln2).
  function automatic logic [INV_W-1:0] channel_rate(input logic [63:0] idx);
    logic [63:0] e;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] res;
    logic [63:0] sh;
    e = (idx * LOG2_1E4_Q32) / TS_DIV;
    f = {32'd0, e[31:0]};
    r = (f * LN2_Q32) >> 32;
    term = 64'd1 << 32;
    pos = term;
    neg = '0;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      term = div_small((term * r) >> 32, k);
      if ((k & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    res = (pos > neg) ? pos - neg : 64'd0;
    if ({32'd0, e[63:32]} > 64'd40) begin
      return '0;
    end
    sh = {32'd0, e[63:32]} + 64'd8;
    return INV_W'((res + (64'd1 << (sh - 64'd1))) >> sh);
  endfunction

  logic [INV_W-1:0] rom_table [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : gen_entry
    assign rom_table[g] = channel_rate(64'(g));
  end

  always_ff @(posedge clk) begin
    data <= rom_table[addr];
  end

endmodule

// ===== design/spe_cordic_cell.sv =====
module spe_cordic_cell
  import spe_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  spe_cell_t cell_in,
  output spe_cell_t cell_out
);

  // Rotation angle atan(2^-SHIFT), full circle = 2^32.
  function automatic logic [PHASE_W-1:0] atan_turns(input int k);
    logic [PHASE_W-1:0] a;
    case (k)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

  localparam logic signed [Z_W-1:0] ANGLE = Z_W'(atan_turns(SHIFT));

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  spe_cell_t              stage_next;

  always_comb begin
    xs = cell_in.x;
    ys = cell_in.y;
    dx = xs >>> SHIFT;
    dy = ys >>> SHIFT;
    stage_next = cell_in;
    if (!cell_in.z[Z_W-1]) begin
      stage_next.x = xs - dy;
      stage_next.y = ys + dx;
      stage_next.z = cell_in.z - ANGLE;
    end else begin
      stage_next.x = xs + dy;
      stage_next.y = ys - dx;
      stage_next.z = cell_in.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    cell_out.zero <= stage_next.zero;
    cell_out.quad <= stage_next.quad;
    cell_out.x    <= stage_next.x;
    cell_out.y    <= stage_next.y;
    cell_out.z    <= stage_next.z;
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= stage_next.valid;
    end
  end

endmodule
